/* hdl/g2e_pkg.sv */
// ----------------------------------------------------------------------------
// g2e_pkg
// Types, constants and arithmetic helpers for the geodetic to ECEF pipeline.
// ----------------------------------------------------------------------------
package g2e_pkg;

  localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
  localparam logic [31:0] HALF_Q32 = 32'h8000_0000;
  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [35:0] N_MAX    = 36'hF_FFFF_FFFF;

  localparam logic [1:0] REG_SEMI_MAJOR = 2'd0;
  localparam logic [1:0] REG_ECC_SQ     = 2'd1;

  localparam logic [32:0] RESET_SEMI_MAJOR = 33'd6378137000;
  localparam logic [31:0] RESET_ECC_SQ     = 32'd28752143;

  localparam int SIN_STEPS    = 5;
  localparam int TAYLOR_STEPS = 6;

  typedef struct packed {
    logic [32:0] term;
    logic [33:0] sum;
    logic [32:0] prod;
    logic [32:0] q0;
  } ser_t;

  typedef struct packed {
    logic [1:0]  quad;
    logic        swap;
    logic [29:0] rr;
    logic [31:0] x;
    logic [31:0] x2;
    ser_t        sn;
    ser_t        cn;
  } ang_t;

  typedef struct packed {
    logic [32:0] s_mag;
    logic        s_neg;
    logic [32:0] c_mag;
    logic        c_neg;
  } trig_t;

  typedef struct packed {
    logic [64:0] lo;
    logic [38:0] hi;
  } part_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [35:0] quo;
  } div_t;

  typedef struct packed {
    logic signed [31:0] alt;
    ang_t               lat;
    ang_t               lon;
    trig_t              tlat;
    trig_t              tlon;
    logic [32:0]        s2;
    logic [32:0]        g;
    sqrt_t              sq;
    logic               sat;
    div_t               dv;
    logic [35:0]        n;
    part_t              pp;
    part_t              pz;
    logic [37:0]        polar;
    logic signed [37:0] h;
    logic signed [37:0] k;
    logic [37:0]        hm;
    logic [37:0]        km;
    logic               hneg;
    logic               kneg;
    logic [37:0]        m1;
    logic [37:0]        mz;
    logic [37:0]        mx;
    logic [37:0]        my;
    logic               neg1;
    logic               negz;
    logic               negx;
    logic               negy;
    logic signed [35:0] ox;
    logic signed [35:0] oy;
    logic signed [35:0] oz;
  } item_t;

  function automatic logic [7:0] sin_div(input int k);
    case (k)
      1:       return 8'd6;
      2:       return 8'd20;
      3:       return 8'd42;
      4:       return 8'd72;
      5:       return 8'd110;
      default: return 8'd1;
    endcase
  endfunction

  function automatic logic [7:0] cos_div(input int k);
    case (k)
      1:       return 8'd2;
      2:       return 8'd12;
      3:       return 8'd30;
      4:       return 8'd56;
      5:       return 8'd90;
      6:       return 8'd132;
      default: return 8'd1;
    endcase
  endfunction

  function automatic ang_t ang_init(input logic [31:0] phase);
    ang_t a;
    a      = '0;
    a.quad = phase[31:30];
    a.swap = phase[29:0] > 30'h2000_0000;
    a.rr   = a.swap ? 30'(31'h4000_0000 - {1'b0, phase[29:0]}) : phase[29:0];
    return a;
  endfunction

  function automatic logic [31:0] ang_x(input logic [29:0] rr);
    logic [63:0] p;
    p = 64'(rr) * 64'(PI_Q30) + 64'h1000_0000;
    return p[60:29];
  endfunction

  function automatic logic [31:0] sq_q32(input logic [31:0] x);
    logic [63:0] p;
    p = 64'(x) * 64'(x) + 64'(HALF_Q32);
    return p[63:32];
  endfunction

  function automatic ser_t ser_mul(input ser_t s, input logic [31:0] x2);
    logic [64:0] p;
    ser_t        r;
    r      = s;
    p      = 65'(s.term) * 65'(x2) + 65'(HALF_Q32);
    r.prod = p[64:32];
    return r;
  endfunction

  function automatic ser_t ser_recip(input ser_t s, input logic [33:0] rc);
    logic [66:0] p;
    ser_t        r;
    r    = s;
    p    = 67'(s.prod) * 67'(rc);
    r.q0 = p[66:34];
    return r;
  endfunction

  // quotient estimate is at most one short
  function automatic ser_t ser_fix(input ser_t s, input logic [7:0] d, input logic sub);
    logic [40:0] qd;
    logic [32:0] rem;
    logic [32:0] q;
    ser_t        r;
    r      = s;
    qd     = 41'(s.q0) * 41'(d);
    rem    = s.prod - qd[32:0];
    q      = s.q0 + 33'(rem >= 33'(d));
    r.term = q;
    r.sum  = sub ? s.sum - 34'(q) : s.sum + 34'(q);
    return r;
  endfunction

  function automatic trig_t to_trig(input ang_t a);
    logic [32:0] sa;
    logic [32:0] ca;
    trig_t       t;
    sa = a.swap ? a.cn.sum[32:0] : a.sn.sum[32:0];
    ca = a.swap ? a.sn.sum[32:0] : a.cn.sum[32:0];
    case (a.quad)
      2'd0:    t = '{s_mag: sa, s_neg: 1'b0, c_mag: ca, c_neg: 1'b0};
      2'd1:    t = '{s_mag: ca, s_neg: 1'b0, c_mag: sa, c_neg: 1'b1};
      2'd2:    t = '{s_mag: sa, s_neg: 1'b1, c_mag: ca, c_neg: 1'b1};
      default: t = '{s_mag: ca, s_neg: 1'b1, c_mag: sa, c_neg: 1'b0};
    endcase
    return t;
  endfunction

  function automatic sqrt_t sq_step(input sqrt_t s, input logic [1:0] pair);
    logic [35:0] t;
    logic [35:0] trial;
    sqrt_t       r;
    t     = {s.rem, pair};
    trial = {2'b00, s.root, 2'b01};
    if (t >= trial) begin
      r.rem  = 34'(t - trial);
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = t[33:0];
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic div_t dv_step(input div_t d, input logic b, input logic [31:0] den);
    logic [32:0] t;
    div_t        r;
    t = {d.rem, b};
    if (t >= {1'b0, den}) begin
      r.rem = 32'(t - {1'b0, den});
      r.quo = {d.quo[34:0], 1'b1};
    end else begin
      r.rem = t[31:0];
      r.quo = {d.quo[34:0], 1'b0};
    end
    return r;
  endfunction

  function automatic part_t mul_part(input logic [37:0] a, input logic [32:0] b);
    part_t p;
    p.lo = 65'(a[31:0]) * 65'(b);
    p.hi = 39'(a[37:32]) * 39'(b);
    return p;
  endfunction

  function automatic logic [37:0] mul_join(input part_t p);
    logic [64:0] l;
    logic [39:0] t;
    l = p.lo + 65'(HALF_Q32);
    t = 40'(p.hi) + 40'(l[64:32]);
    return t[37:0];
  endfunction

  function automatic logic signed [35:0] sat_coord(input logic [37:0] m, input logic neg);
    logic signed [38:0] v;
    v = $signed({1'b0, m});
    if (neg) begin
      v = -v;
    end
    if (v > 39'sd34359738367) begin
      return 36'sh7_FFFF_FFFF;
    end else if (v < -39'sd34359738368) begin
      return 36'sh8_0000_0000;
    end
    return v[35:0];
  endfunction

endpackage

/* hdl/g2e_in_if.sv */
// ----------------------------------------------------------------------------
// g2e_in_if
// Geodetic position stream: valid/ready with latitude, longitude, altitude.
// ----------------------------------------------------------------------------
interface g2e_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] latitude;
  logic signed [31:0] longitude;
  logic signed [31:0] altitude_mm;

  modport source (output valid, output latitude, output longitude, output altitude_mm,
                  input ready);
  modport sink (input valid, input latitude, input longitude, input altitude_mm,
                output ready);
endinterface

/* hdl/g2e_out_if.sv */
// ----------------------------------------------------------------------------
// g2e_out_if
// ECEF position stream: valid/ready with X, Y and Z in millimetres.
// ----------------------------------------------------------------------------
interface g2e_out_if;
  logic               valid;
  logic               ready;
  logic signed [35:0] ecef_x_mm;
  logic signed [35:0] ecef_y_mm;
  logic signed [35:0] ecef_z_mm;

  modport source (output valid, output ecef_x_mm, output ecef_y_mm, output ecef_z_mm,
                  input ready);
  modport sink (input valid, input ecef_x_mm, input ecef_y_mm, input ecef_z_mm,
                output ready);
endinterface

/* hdl/geodetic_to_ecef.sv */
// ----------------------------------------------------------------------------
// geodetic_to_ecef
// Pipelined geodetic (lat, lon, alt) to earth-centred earth-fixed conversion.
//
//   channel   dir   transfer payload
//   geo       in    latitude, longitude, altitude_mm
//   ecef      out   ecef_x_mm, ecef_y_mm, ecef_z_mm
//   cfg_*     in    register write (no handshake)
//
// One transfer per cycle sustained while the output is not stalled, through 69 register
// stages (Taylor sine/cosine, two-bit-a-stage square root and division,
// split Q32 products). Each stage holds its own valid and advances when it
// is empty or the next one advances, so bubbles close up and a stalled
// output holds without loss. Reset clears the valids and loads the
// ellipsoid registers with WGS84.
// ----------------------------------------------------------------------------
module geodetic_to_ecef
  import g2e_pkg::*;
#(
  parameter int ANGLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [32:0] cfg_data,
  g2e_in_if.sink      geo,
  g2e_out_if.source   ecef
);

  localparam int          DROP  = (ANGLE_BITS < 32) ? (32 - ANGLE_BITS) : 0;
  localparam logic [31:0] AMASK = 32'hFFFF_FFFF << DROP;

  localparam int S_X2    = 2;
  localparam int T0      = 3;
  localparam int S_TRIG  = T0 + 3 * TAYLOR_STEPS;
  localparam int S_S2    = S_TRIG + 1;
  localparam int S_G     = S_S2 + 1;
  localparam int Q0      = S_G + 1;
  localparam int S_DINIT = Q0 + 16;
  localparam int D0      = S_DINIT + 1;
  localparam int S_N     = D0 + 18;
  localparam int S_PP    = S_N + 1;
  localparam int S_POL   = S_PP + 1;
  localparam int S_HK    = S_POL + 1;
  localparam int S_MAG   = S_HK + 1;
  localparam int S_P1    = S_MAG + 1;
  localparam int S_J1    = S_P1 + 1;
  localparam int S_P2    = S_J1 + 1;
  localparam int S_J2    = S_P2 + 1;
  localparam int LAST    = S_J2 + 1;

  logic [32:0] semi_major;
  logic [31:0] ecc_sq;

  item_t pipe [LAST+1];
  item_t nxt  [LAST+1];
  logic  v    [LAST+1];
  logic  en   [LAST+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      semi_major <= RESET_SEMI_MAJOR;
      ecc_sq     <= RESET_ECC_SQ;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SEMI_MAJOR: semi_major <= cfg_data;
        REG_ECC_SQ:     ecc_sq     <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign en[LAST] = !v[LAST] || ecef.ready;

  for (genvar s = 0; s <= LAST; s++) begin : g_stage
    if (s < LAST) begin : g_en
      assign en[s] = !v[s] || en[s+1];
    end

    if (s == 0) begin : g_in
      always_comb begin
        nxt[s]     = '0;
        nxt[s].alt = geo.altitude_mm;
        nxt[s].lat = ang_init(geo.latitude & AMASK);
        nxt[s].lon = ang_init(geo.longitude & AMASK);
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          v[s] <= 1'b0;
        end else if (en[s]) begin
          v[s] <= geo.valid;
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (rst) begin
          v[s] <= 1'b0;
        end else if (en[s]) begin
          v[s] <= v[s-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        pipe[s] <= nxt[s];
      end
    end

    if (s == 1) begin : g_x
      always_comb begin
        nxt[s]       = pipe[s-1];
        nxt[s].lat.x = ang_x(pipe[s-1].lat.rr);
        nxt[s].lon.x = ang_x(pipe[s-1].lon.rr);
      end
    end else if (s == S_X2) begin : g_x2
      always_comb begin
        nxt[s]             = pipe[s-1];
        nxt[s].lat.x2      = sq_q32(pipe[s-1].lat.x);
        nxt[s].lon.x2      = sq_q32(pipe[s-1].lon.x);
        nxt[s].lat.sn.term = {1'b0, pipe[s-1].lat.x};
        nxt[s].lat.sn.sum  = {2'b00, pipe[s-1].lat.x};
        nxt[s].lon.sn.term = {1'b0, pipe[s-1].lon.x};
        nxt[s].lon.sn.sum  = {2'b00, pipe[s-1].lon.x};
        nxt[s].lat.cn.term = ONE_Q32;
        nxt[s].lat.cn.sum  = {1'b0, ONE_Q32};
        nxt[s].lon.cn.term = ONE_Q32;
        nxt[s].lon.cn.sum  = {1'b0, ONE_Q32};
      end
    end else if (s >= T0 && s < S_TRIG) begin : g_taylor
      localparam int          K   = (s - T0) / 3 + 1;
      localparam int          PH  = (s - T0) % 3;
      localparam logic [7:0]  DS  = sin_div(K);
      localparam logic [7:0]  DC  = cos_div(K);
      localparam logic [33:0] RS  = 34'((64'd1 << 34) / 64'(DS));
      localparam logic [33:0] RC  = 34'((64'd1 << 34) / 64'(DC));
      localparam logic        SUB = (K % 2) == 1;
      localparam logic        SON = K <= SIN_STEPS;
      always_comb begin
        nxt[s] = pipe[s-1];
        if (PH == 0) begin
          nxt[s].lat.cn = ser_mul(pipe[s-1].lat.cn, pipe[s-1].lat.x2);
          nxt[s].lon.cn = ser_mul(pipe[s-1].lon.cn, pipe[s-1].lon.x2);
          if (SON) begin
            nxt[s].lat.sn = ser_mul(pipe[s-1].lat.sn, pipe[s-1].lat.x2);
            nxt[s].lon.sn = ser_mul(pipe[s-1].lon.sn, pipe[s-1].lon.x2);
          end
        end else if (PH == 1) begin
          nxt[s].lat.cn = ser_recip(pipe[s-1].lat.cn, RC);
          nxt[s].lon.cn = ser_recip(pipe[s-1].lon.cn, RC);
          if (SON) begin
            nxt[s].lat.sn = ser_recip(pipe[s-1].lat.sn, RS);
            nxt[s].lon.sn = ser_recip(pipe[s-1].lon.sn, RS);
          end
        end else begin
          nxt[s].lat.cn = ser_fix(pipe[s-1].lat.cn, DC, SUB);
          nxt[s].lon.cn = ser_fix(pipe[s-1].lon.cn, DC, SUB);
          if (SON) begin
            nxt[s].lat.sn = ser_fix(pipe[s-1].lat.sn, DS, SUB);
            nxt[s].lon.sn = ser_fix(pipe[s-1].lon.sn, DS, SUB);
          end
        end
      end
    end else if (s == S_TRIG) begin : g_trig
      always_comb begin
        nxt[s]      = pipe[s-1];
        nxt[s].tlat = to_trig(pipe[s-1].lat);
        nxt[s].tlon = to_trig(pipe[s-1].lon);
      end
    end else if (s == S_S2) begin : g_s2
      logic [63:0] sq;
      always_comb begin
        nxt[s] = pipe[s-1];
        sq     = 64'(pipe[s-1].tlat.s_mag[31:0]) * 64'(pipe[s-1].tlat.s_mag[31:0]);
        nxt[s].s2 = pipe[s-1].tlat.s_mag[32] ? ONE_Q32 : {1'b0, sq[63:32]};
      end
    end else if (s == S_G) begin : g_g
      logic [64:0] es;
      logic [32:0] gv;
      always_comb begin
        nxt[s]    = pipe[s-1];
        es        = 65'(ecc_sq) * 65'(pipe[s-1].s2) + 65'(HALF_Q32);
        gv        = ONE_Q32 - es[64:32];
        nxt[s].g  = (gv == '0) ? 33'd1 : gv;
        nxt[s].sq = '0;
      end
    end else if (s >= Q0 && s < S_DINIT) begin : g_sqrt
      localparam int P0 = 31 - 2 * (s - Q0);
      localparam int P1 = P0 - 1;
      logic [63:0] rad;
      always_comb begin
        nxt[s]    = pipe[s-1];
        rad       = {1'b0, pipe[s-1].g, 30'b0};
        nxt[s].sq = sq_step(sq_step(pipe[s-1].sq, rad[2*P0+1 -: 2]), rad[2*P1+1 -: 2]);
      end
    end else if (s == S_DINIT) begin : g_dinit
      always_comb begin
        nxt[s]        = pipe[s-1];
        nxt[s].sat    = 37'(semi_major) >= {pipe[s-1].sq.root, 5'b0};
        nxt[s].dv.rem = 32'(semi_major[32:5]);
        nxt[s].dv.quo = '0;
      end
    end else if (s >= D0 && s < S_N) begin : g_div
      localparam int B0 = 35 - 2 * (s - D0);
      localparam int B1 = B0 - 1;
      logic [35:0] num;
      always_comb begin
        nxt[s]    = pipe[s-1];
        num       = {semi_major[4:0], 31'b0};
        nxt[s].dv = dv_step(dv_step(pipe[s-1].dv, num[B0], pipe[s-1].sq.root),
                            num[B1], pipe[s-1].sq.root);
      end
    end else if (s == S_N) begin : g_n
      always_comb begin
        nxt[s]   = pipe[s-1];
        nxt[s].n = pipe[s-1].sat ? N_MAX : pipe[s-1].dv.quo;
      end
    end else if (s == S_PP) begin : g_pp
      always_comb begin
        nxt[s]    = pipe[s-1];
        nxt[s].pp = mul_part({2'b00, pipe[s-1].n}, ONE_Q32 - {1'b0, ecc_sq});
      end
    end else if (s == S_POL) begin : g_pol
      always_comb begin
        nxt[s]       = pipe[s-1];
        nxt[s].polar = mul_join(pipe[s-1].pp);
      end
    end else if (s == S_HK) begin : g_hk
      always_comb begin
        nxt[s]   = pipe[s-1];
        nxt[s].h = $signed({2'b00, pipe[s-1].n}) + 38'(pipe[s-1].alt);
        nxt[s].k = $signed(pipe[s-1].polar) + 38'(pipe[s-1].alt);
      end
    end else if (s == S_MAG) begin : g_mag
      always_comb begin
        nxt[s]      = pipe[s-1];
        nxt[s].hneg = pipe[s-1].h < 0;
        nxt[s].kneg = pipe[s-1].k < 0;
        nxt[s].hm   = (pipe[s-1].h < 0) ? 38'(-pipe[s-1].h) : 38'(pipe[s-1].h);
        nxt[s].km   = (pipe[s-1].k < 0) ? 38'(-pipe[s-1].k) : 38'(pipe[s-1].k);
      end
    end else if (s == S_P1) begin : g_p1
      always_comb begin
        nxt[s]    = pipe[s-1];
        nxt[s].pp = mul_part(pipe[s-1].hm, pipe[s-1].tlat.c_mag);
        nxt[s].pz = mul_part(pipe[s-1].km, pipe[s-1].tlat.s_mag);
      end
    end else if (s == S_J1) begin : g_j1
      always_comb begin
        nxt[s]      = pipe[s-1];
        nxt[s].m1   = mul_join(pipe[s-1].pp);
        nxt[s].mz   = mul_join(pipe[s-1].pz);
        nxt[s].neg1 = pipe[s-1].hneg ^ pipe[s-1].tlat.c_neg;
        nxt[s].negz = pipe[s-1].kneg ^ pipe[s-1].tlat.s_neg;
      end
    end else if (s == S_P2) begin : g_p2
      always_comb begin
        nxt[s]    = pipe[s-1];
        nxt[s].pp = mul_part(pipe[s-1].m1, pipe[s-1].tlon.c_mag);
        nxt[s].pz = mul_part(pipe[s-1].m1, pipe[s-1].tlon.s_mag);
      end
    end else if (s == S_J2) begin : g_j2
      always_comb begin
        nxt[s]      = pipe[s-1];
        nxt[s].mx   = mul_join(pipe[s-1].pp);
        nxt[s].my   = mul_join(pipe[s-1].pz);
        nxt[s].negx = pipe[s-1].neg1 ^ pipe[s-1].tlon.c_neg;
        nxt[s].negy = pipe[s-1].neg1 ^ pipe[s-1].tlon.s_neg;
      end
    end else if (s == LAST) begin : g_out
      always_comb begin
        nxt[s]    = pipe[s-1];
        nxt[s].ox = sat_coord(pipe[s-1].mx, pipe[s-1].negx);
        nxt[s].oy = sat_coord(pipe[s-1].my, pipe[s-1].negy);
        nxt[s].oz = sat_coord(pipe[s-1].mz, pipe[s-1].negz);
      end
    end
  end

  assign geo.ready      = en[0];
  assign ecef.valid     = v[LAST];
  assign ecef.ecef_x_mm = pipe[LAST].ox;
  assign ecef.ecef_y_mm = pipe[LAST].oy;
  assign ecef.ecef_z_mm = pipe[LAST].oz;

endmodule

/* verif/geodetic_to_ecef_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geodetic_to_ecef_tb
// Streams geodetic positions through the converter under several ellipsoid
// settings, with random gaps on the input and stalls on the output. A
// fixed-point ECEF predictor in the scoreboard checks every result in order.
// ----------------------------------------------------------------------------
module geodetic_to_ecef_tb
  import g2e_pkg::*;
();

  localparam longint unsigned UNIT_Q32 = 64'h1_0000_0000;
  localparam longint unsigned PI_Q30_C = 64'd3373259426;
  localparam longint unsigned RADIUS_MAX = 64'hF_FFFF_FFFF;
  localparam longint COORD_HI = 64'sd34359738367;
  localparam longint COORD_LO = -64'sd34359738368;
  localparam int DRAIN_CYCLES = 90;

  typedef struct {
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [35:0] z;
  } ecef_pos_t;

  class ecef_scoreboard;
    longint unsigned semi_major;
    longint unsigned ecc_sq;
    ecef_pos_t       expected_pos[$];
    int              errors;

    function new();
      semi_major = 64'd6378137000;
      ecc_sq     = 64'd28752143;
      errors     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [32:0] data);
      if (idx == REG_SEMI_MAJOR) semi_major = 64'(data);
      else if (idx == REG_ECC_SQ) ecc_sq = 64'(data[31:0]);
    endfunction

    function longint unsigned q32_mul(longint unsigned a, longint unsigned b);
      return (a >> 32) * b + (((a & 64'hFFFF_FFFF) * b + 64'h8000_0000) >> 32);
    endfunction

    function longint q32_smul(longint a, longint b);
      longint unsigned ma;
      longint unsigned mb;
      longint unsigned m;
      ma = (a < 0) ? longint'(-a) : a;
      mb = (b < 0) ? longint'(-b) : b;
      m  = q32_mul(ma, mb);
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint unsigned series(longint unsigned r, bit want_sin);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned d;
      int              last;
      x    = (r * PI_Q30_C + (64'd1 << 28)) >> 29;
      x2   = q32_mul(x, x);
      term = want_sin ? x : UNIT_Q32;
      sum  = term;
      last = want_sin ? 5 : 6;
      for (int k = 1; k <= last; k++) begin
        d    = want_sin ? 64'((2 * k) * (2 * k + 1)) : 64'((2 * k - 1) * (2 * k));
        term = q32_mul(term, x2) / d;
        if (k & 1) sum = sum - term;
        else sum = sum + term;
      end
      return sum;
    endfunction

    function void sin_cos(logic [31:0] ph, output longint s, output longint c);
      longint unsigned r;
      longint sa;
      longint ca;
      r = 64'(ph[29:0]);
      if (r <= (64'd1 << 29)) begin
        sa = series(r, 1'b1);
        ca = series(r, 1'b0);
      end else begin
        sa = series((64'd1 << 30) - r, 1'b0);
        ca = series((64'd1 << 30) - r, 1'b1);
      end
      case (ph[31:30])
        2'd0:    begin s = sa;  c = ca;  end
        2'd1:    begin s = ca;  c = -sa; end
        2'd2:    begin s = -sa; c = -ca; end
        default: begin s = -ca; c = sa;  end
      endcase
    endfunction

    function logic signed [35:0] clamp36(longint v);
      if (v > COORD_HI) v = COORD_HI;
      if (v < COORD_LO) v = COORD_LO;
      return v[35:0];
    endfunction

    function void note_position(logic [31:0] lat, logic [31:0] lon, logic signed [31:0] alt);
      longint slat, clat, slon, clon, h, kz;
      longint unsigned ms, s2, g, root, n;
      ecef_pos_t p;
      sin_cos(lat, slat, clat);
      sin_cos(lon, slon, clon);
      ms = (slat < 0) ? longint'(-slat) : slat;
      s2 = (ms >= UNIT_Q32) ? UNIT_Q32 : ((ms * ms) >> 32);
      g  = UNIT_Q32 - q32_mul(ecc_sq, s2);
      if (g == 0) g = 1;
      root = int_sqrt(g << 30);
      n    = (semi_major << 31) / root;
      if (n > RADIUS_MAX) n = RADIUS_MAX;
      h  = longint'(n) + longint'(alt);
      kz = longint'(q32_mul(n, UNIT_Q32 - ecc_sq)) + longint'(alt);
      p.x = clamp36(q32_smul(q32_smul(h, clat), clon));
      p.y = clamp36(q32_smul(q32_smul(h, clat), slon));
      p.z = clamp36(q32_smul(kz, slat));
      expected_pos.push_back(p);
    endfunction

    function void check_position(logic signed [35:0] x, logic signed [35:0] y,
                                 logic signed [35:0] z);
      ecef_pos_t p;
      if (expected_pos.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time, x, y, z);
        errors++;
        return;
      end
      p = expected_pos.pop_front();
      if (x !== p.x) begin
        $display("%0t: ecef_x_mm expected %0d actual %0d", $time, p.x, x);
        errors++;
      end
      if (y !== p.y) begin
        $display("%0t: ecef_y_mm expected %0d actual %0d", $time, p.y, y);
        errors++;
      end
      if (z !== p.z) begin
        $display("%0t: ecef_z_mm expected %0d actual %0d", $time, p.z, z);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [32:0] cfg_data;
  bit          calm;
  int          stall_left;

  g2e_in_if  geo_if();
  g2e_out_if ecef_if();

  ecef_scoreboard sb;

  geodetic_to_ecef dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geo       (geo_if),
    .ecef      (ecef_if)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (rst || calm) begin
      ecef_if.ready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left > 0) begin
      ecef_if.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      ecef_if.ready <= 1'b1;
      stall_left    <= gap_len();
    end
  end

  // transfers are noted before results so order within a step does not matter
  always @(posedge clk) begin
    if (!rst) begin
      if (geo_if.valid && geo_if.ready)
        sb.note_position(geo_if.latitude, geo_if.longitude, geo_if.altitude_mm);
      if (ecef_if.valid && ecef_if.ready)
        sb.check_position(ecef_if.ecef_x_mm, ecef_if.ecef_y_mm, ecef_if.ecef_z_mm);
    end
  end

  task automatic send_position(logic [31:0] lat, logic [31:0] lon, logic [31:0] alt);
    int gap;
    geo_if.valid       <= 1'b1;
    geo_if.latitude    <= lat;
    geo_if.longitude   <= lon;
    geo_if.altitude_mm <= alt;
    do @(posedge clk); while (!geo_if.ready);
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      geo_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    geo_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_pos.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [32:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_reg(idx, data);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_angle();
    logic [31:0] corners[8] = '{32'h0, 32'h4000_0000, 32'hC000_0000, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h2000_0000, 32'h6000_0000,
                                32'hE000_0000};
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom();
    return corners[$urandom_range(0, 7)] + 32'($signed($urandom_range(0, 8)) - 4);
  endfunction

  function automatic logic [31:0] pick_altitude();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom();
    if (r < 9) return 32'($signed($urandom_range(0, 20_000_000)) - 1_000_000);
    return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      send_position(pick_angle(), pick_angle(), pick_altitude());
    end
    calm = 1'b0;
    wait_idle();
  endtask

  initial begin
    sb                 = new();
    calm               = 1'b0;
    rst                = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = REG_SEMI_MAJOR;
    cfg_data           = '0;
    geo_if.valid       = 1'b0;
    geo_if.latitude    = '0;
    geo_if.longitude   = '0;
    geo_if.altitude_mm = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: quadrant edges, fold point, wrap at pi, altitude extremes
    send_position(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_position(32'h4000_0000, 32'h0000_0000, 32'h0000_0000);
    send_position(32'hC000_0000, 32'h4000_0000, 32'h0000_0000);
    send_position(32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
    send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_position(32'h8000_0001, 32'hFFFF_FFFF, 32'h8000_0000);
    send_position(32'h2000_0000, 32'h2000_0000, 32'h0000_1000);
    send_position(32'h2000_0001, 32'h1FFF_FFFF, 32'hFFFF_F000);
    send_position(32'h6000_0000, 32'hA000_0000, 32'h7FFF_FFFF);
    send_position(32'h3FFF_FFFF, 32'h4000_0001, 32'h8000_0000);
    send_position(32'hBFFF_FFFF, 32'hE000_0000, 32'h0098_9680);
    send_position(32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
    send_position(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
    random_phase(250);

    write_reg(REG_SEMI_MAJOR, 33'h1_FFFF_FFFF);
    write_reg(REG_ECC_SQ, 33'h0_8000_0000);
    random_phase(250);

    write_reg(REG_SEMI_MAJOR, 33'h0);
    write_reg(REG_ECC_SQ, 33'h0);
    random_phase(150);

    write_reg(REG_SEMI_MAJOR, {1'b0, 32'($urandom())});
    write_reg(REG_ECC_SQ, 33'h1_FFFF_FFFF);
    random_phase(250);

    // out-of-range indexes must leave the ellipsoid alone
    write_reg(REG_SEMI_MAJOR, RESET_SEMI_MAJOR);
    write_reg(REG_ECC_SQ, {1'b1, RESET_ECC_SQ});
    write_reg(2'd2, 33'h1_2345_6789);
    write_reg(2'd3, 33'h0_FFFF_FFFF);
    random_phase(200);

    write_reg(REG_SEMI_MAJOR, {1'b0, 32'($urandom())} + 33'h1_0000_0000);
    write_reg(REG_ECC_SQ, 33'($urandom()));
    random_phase(150);

    if (sb.errors == 0 && sb.expected_pos.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* geodetic_to_ecef.f */
hdl/g2e_pkg.sv
hdl/g2e_in_if.sv
hdl/g2e_out_if.sv
hdl/geodetic_to_ecef.sv
verif/geodetic_to_ecef_tb.sv
